// File: rtl/vcm_pkg.sv
// vcm_pkg: shared types and constants for the vehicle command mixer.
// Used by every module under rtl/; depends on nothing else.
package vcm_pkg;

  localparam int unsigned TICK_W = 8;
  localparam int unsigned CMD_W  = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic signed [CMD_W-1:0] CMD_LIMIT = 11'sd1000;

  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_ARM    = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEER_GAIN     = 3'd0,
    REG_FORWARD_TRIM   = 3'd1,
    REG_REVERSE_TRIM   = 3'd2,
    REG_FORWARD_SCALE  = 3'd3,
    REG_FORWARD_OFFSET = 3'd4,
    REG_REVERSE_SCALE  = 3'd5,
    REG_REVERSE_OFFSET = 3'd6,
    REG_INVERT_MASK    = 3'd7
  } reg_idx_t;

  localparam logic KIND_DRIVE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register file contents
  typedef struct packed {
    logic        [15:0]      steer_gain;
    logic signed [CMD_W-1:0] forward_trim;
    logic signed [CMD_W-1:0] reverse_trim;
    logic        [11:0]      forward_scale;
    logic signed [CMD_W-1:0] forward_offset;
    logic        [11:0]      reverse_scale;
    logic signed [CMD_W-1:0] reverse_offset;
    logic        [1:0]       invert_mask;
  } cfg_t;

  // per-request control decided at accept time
  typedef struct packed {
    logic emit;
    logic kind;
    logic armed_flag;
    logic override_flag;
  } req_ctl_t;

endpackage

// File: rtl/vcm_cfg.sv
// vcm_cfg: configuration register file of the command mixer.
// Depends on vcm_pkg.
module vcm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [vcm_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [vcm_pkg::CFG_DATA_W-1:0]      wr_data,
  output vcm_pkg::cfg_t                       cfg
);
  import vcm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_STEER_GAIN:     cfg_nxt.steer_gain     = wr_data;
        REG_FORWARD_TRIM:   cfg_nxt.forward_trim   = wr_data[CMD_W-1:0];
        REG_REVERSE_TRIM:   cfg_nxt.reverse_trim   = wr_data[CMD_W-1:0];
        REG_FORWARD_SCALE:  cfg_nxt.forward_scale  = wr_data[11:0];
        REG_FORWARD_OFFSET: cfg_nxt.forward_offset = wr_data[CMD_W-1:0];
        REG_REVERSE_SCALE:  cfg_nxt.reverse_scale  = wr_data[11:0];
        REG_REVERSE_OFFSET: cfg_nxt.reverse_offset = wr_data[CMD_W-1:0];
        REG_INVERT_MASK:    cfg_nxt.invert_mask    = wr_data[1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steer_gain     <= 16'd1908;
      cfg_r.forward_trim   <= -11'sd90;
      cfg_r.reverse_trim   <= 11'sd75;
      cfg_r.forward_scale  <= 12'd143;
      cfg_r.forward_offset <= 11'sd27;
      cfg_r.reverse_scale  <= 12'd143;
      cfg_r.reverse_offset <= -11'sd27;
      cfg_r.invert_mask    <= 2'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/vcm_ctrl.sv
// vcm_ctrl: arming / override state and the input request register.
// Depends on vcm_pkg.
module vcm_ctrl #(
  parameter int TIMEOUT_TICKS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                drain,
  input  logic [1:0]          mode,
  input  logic signed [15:0]  linear_speed,
  input  logic signed [15:0]  turn_rate,
  input  logic                armed_in,
  output logic                req_valid,
  output vcm_pkg::req_ctl_t   req_ctl,
  output logic signed [15:0]  req_speed,
  output logic signed [15:0]  req_turn
);
  import vcm_pkg::*;

  logic              armed_r, armed_nxt;
  logic              ovr_r, ovr_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [TICK_W-1:0] ticks_inc;
  logic              valid_r, valid_nxt;
  req_ctl_t          ctl_r, ctl_nxt;
  logic signed [15:0] speed_r, turn_r;

  assign ticks_inc = (ticks_r != '1) ? ticks_r + 1'b1 : ticks_r;

  always_comb begin
    armed_nxt = armed_r;
    ovr_nxt   = ovr_r;
    ticks_nxt = ticks_r;
    ctl_nxt   = '0;
    if (accept) begin
      case (mode_t'(mode))
        MODE_AUTO: begin
          ctl_nxt.emit          = armed_r && !ovr_r;
          ctl_nxt.kind          = KIND_DRIVE;
          ctl_nxt.armed_flag    = 1'b1;
          ctl_nxt.override_flag = ovr_r;
        end
        MODE_MANUAL: begin
          ticks_nxt             = '0;
          ovr_nxt               = 1'b1;
          ctl_nxt.emit          = armed_r;
          ctl_nxt.kind          = KIND_DRIVE;
          ctl_nxt.armed_flag    = 1'b1;
          ctl_nxt.override_flag = 1'b1;
        end
        MODE_ARM: begin
          armed_nxt = armed_in;
        end
        MODE_TICK: begin
          ticks_nxt = ticks_inc;
          if (ticks_inc > TICK_W'(TIMEOUT_TICKS)) begin
            ovr_nxt = 1'b0;
          end
          ctl_nxt.emit          = 1'b1;
          ctl_nxt.kind          = KIND_STATUS;
          ctl_nxt.armed_flag    = armed_r;
          ctl_nxt.override_flag = ovr_nxt;
        end
        default: ctl_nxt = '0;
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      ovr_r   <= 1'b0;
      ticks_r <= '1;
      valid_r <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      ovr_r   <= ovr_nxt;
      ticks_r <= ticks_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r   <= ctl_nxt;
      speed_r <= linear_speed;
      turn_r  <= turn_rate;
    end
  end

  assign req_valid = valid_r;
  assign req_ctl   = ctl_r;
  assign req_speed = speed_r;
  assign req_turn  = turn_r;

endmodule

// File: rtl/vcm_mix.sv
// vcm_mix: steering / throttle mixing, inversion, direction rule and clamps.
// Purely combinational; depends on vcm_pkg.
module vcm_mix (
  input  vcm_pkg::cfg_t                       cfg,
  input  logic signed [15:0]                  speed,
  input  logic signed [15:0]                  turn,
  output logic signed [vcm_pkg::CMD_W-1:0]    steering,
  output logic signed [vcm_pkg::CMD_W-1:0]    throttle
);
  import vcm_pkg::*;

  function automatic logic signed [CMD_W-1:0] clamp27(input logic signed [26:0] v);
    logic signed [26:0] lim;
    lim = 27'(CMD_LIMIT);
    if (v > lim) begin
      clamp27 = CMD_LIMIT;
    end else if (v < -lim) begin
      clamp27 = -CMD_LIMIT;
    end else begin
      clamp27 = v[CMD_W-1:0];
    end
  endfunction

  logic               spd_pos, spd_neg, fwd;
  logic signed [32:0] steer_prod;
  logic signed [24:0] steer_sh;
  logic signed [25:0] steer_trim, steer_sum;
  logic signed [26:0] steer_fin;
  logic signed [28:0] thr_prod;
  logic signed [20:0] thr_sh;
  logic signed [21:0] thr_sum;
  logic signed [22:0] thr_fin;
  logic [12:0]        scale_sel;
  logic signed [CMD_W-1:0] offs_sel;

  assign spd_neg = speed[15];
  assign spd_pos = !speed[15] && (speed != '0);

  // steering: floor((turn * gain) / 256) + trim
  assign steer_prod = turn * $signed({1'b0, cfg.steer_gain});
  assign steer_sh   = steer_prod[32:8];
  assign steer_trim = spd_pos ? 26'(cfg.forward_trim) :
                      spd_neg ? 26'(cfg.reverse_trim) : '0;
  assign steer_sum  = 26'(steer_sh) + steer_trim;
  assign steer_fin  = cfg.invert_mask[1] ? -27'(steer_sum) : 27'(steer_sum);
  assign steering   = clamp27(steer_fin);

  // throttle: floor((speed * scale) / 256) + offset, zero when stopped
  assign scale_sel = {1'b0, spd_pos ? cfg.forward_scale : cfg.reverse_scale};
  assign offs_sel  = spd_pos ? cfg.forward_offset : cfg.reverse_offset;
  assign thr_prod  = speed * $signed(scale_sel);
  assign thr_sh    = thr_prod[28:8];
  assign thr_sum   = (spd_pos || spd_neg) ? 22'(thr_sh) + 22'(offs_sel) : '0;
  assign thr_fin   = cfg.invert_mask[0] ? -23'(thr_sum) : 23'(thr_sum);
  assign fwd       = spd_pos ^ cfg.invert_mask[0];

  always_comb begin
    if (fwd && thr_fin < 0) begin
      throttle = '0;
    end else if (!fwd && thr_fin > 0) begin
      throttle = '0;
    end else begin
      throttle = clamp27(27'(thr_fin));
    end
  end

endmodule

// File: rtl/vehicle_command_mixer_top.sv
// vehicle_command_mixer_top: top level of the vehicle command mixer.
// Instantiates vcm_cfg, vcm_ctrl and vcm_mix; depends on vcm_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one request: mode, linear
//    speed and turn rate (Q7.8) and the armed bit for arm updates.
//  - Result channel (out_valid / out_stall) carries drive commands
//    (kind 0, steering and throttle in -1000..1000) and status reports
//    (kind 1, one per tick request, steering and throttle zero).
//    Autonomous requests during manual override, drive requests while
//    disarmed, and arm updates produce no result.
//  - Config channel (cfg_valid / cfg_ready) writes the gain, trim, scale,
//    offset and invert registers; cfg_ready is always high. Write only
//    while no request is in flight.
//  - Pipeline: an accepted request passes the request register, then the
//    result register with the mixer between.
//  - Throughput: one request per cycle while in_stall is low; arm / override /
//    tick state is updated at accept time, so back-to-back requests see each other.
//  - Stall: with out_stall high the result holds; one more request may be
//    taken into the request register, after which in_stall rises.
//  - Reset (rst_n low, synchronous): disarmed, override off, tick count
//    saturated, registers at their defaults, both stages empty.
module vehicle_command_mixer_top #(
  parameter int TIMEOUT_TICKS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_mode,
  input  logic signed [15:0]                  in_linear_speed,
  input  logic signed [15:0]                  in_turn_rate,
  input  logic                                in_armed_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic signed [vcm_pkg::CMD_W-1:0]    out_steering,
  output logic signed [vcm_pkg::CMD_W-1:0]    out_throttle,
  output logic                                out_armed_flag,
  output logic                                out_override_flag,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vcm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vcm_pkg::*;

  cfg_t               cfg;
  req_ctl_t           req_ctl;
  logic               req_valid;
  logic signed [15:0] req_speed, req_turn;
  logic signed [CMD_W-1:0] mix_steer, mix_thr;
  logic               out_load, in_accept;

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, armed_flag_r, ovr_flag_r;
  logic signed [CMD_W-1:0] steer_r, thr_r;

  // result register takes new data when empty or being drained
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = req_valid && !out_load;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  vcm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vcm_ctrl #(
    .TIMEOUT_TICKS (TIMEOUT_TICKS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .drain        (out_load),
    .mode         (in_mode),
    .linear_speed (in_linear_speed),
    .turn_rate    (in_turn_rate),
    .armed_in     (in_armed_in),
    .req_valid    (req_valid),
    .req_ctl      (req_ctl),
    .req_speed    (req_speed),
    .req_turn     (req_turn)
  );

  vcm_mix u_mix (
    .cfg      (cfg),
    .speed    (req_speed),
    .turn     (req_turn),
    .steering (mix_steer),
    .throttle (mix_thr)
  );

  assign out_valid_nxt = out_load ? (req_valid && req_ctl.emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && req_valid) begin
      kind_r       <= req_ctl.kind;
      armed_flag_r <= req_ctl.armed_flag;
      ovr_flag_r   <= req_ctl.override_flag;
      // status reports carry zero steering and throttle
      steer_r      <= (req_ctl.kind == KIND_STATUS) ? '0 : mix_steer;
      thr_r        <= (req_ctl.kind == KIND_STATUS) ? '0 : mix_thr;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_steering      = steer_r;
  assign out_throttle      = thr_r;
  assign out_armed_flag    = armed_flag_r;
  assign out_override_flag = ovr_flag_r;

endmodule

// File: rtl/vcm_checker.sv
// vcm_checker: port-level checks on the command mixer top, bound below.
// Depends on vcm_pkg and vehicle_command_mixer_top.
module vcm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_kind,
  input logic signed [vcm_pkg::CMD_W-1:0] out_steering,
  input logic signed [vcm_pkg::CMD_W-1:0] out_throttle,
  input logic                             out_armed_flag
);
  import vcm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_steering) && $stable(out_throttle))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_drive_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DRIVE |-> out_armed_flag)
    else $error("drive command while disarmed");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_steering == '0 && out_throttle == '0)
    else $error("status report with nonzero command");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_steering >= -CMD_LIMIT && out_steering <= CMD_LIMIT &&
                  out_throttle >= -CMD_LIMIT && out_throttle <= CMD_LIMIT)
    else $error("command outside limit");

endmodule

bind vehicle_command_mixer_top vcm_checker u_vcm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_steering   (out_steering),
  .out_throttle   (out_throttle),
  .out_armed_flag (out_armed_flag)
);

// File: tb/vehicle_command_mixer_top_test.sv
// vehicle_command_mixer_top_test: self-checking bench for the vehicle command mixer.
// Drives directed and random requests and config writes; checks each result against the
// predictor or a typed row. Depends on rtl/vcm_pkg.sv and vehicle_command_mixer_top.
module vehicle_command_mixer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vcm_pkg::*;

  localparam int TIMEOUT_TICKS = 20;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;   // counted requests per random phase
  localparam int LONG_HOLD     = 64;    // receiver hold-off for the back-pressure test
  localparam int IDLE_LIMIT    = 1000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES  = 4;     // settle margin after the last expected result

  // one expected result
  typedef struct packed {
    logic                    kind;
    logic signed [CMD_W-1:0] steer;
    logic signed [CMD_W-1:0] thr;
    logic                    armed;
    logic                    ovr;
  } cmd_t;

  // directed stimulus row; 'typed' rows carry a hand-written expected result
  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
    logic               arm;
    int unsigned        reps;
    bit                 typed;
    cmd_t               want;
  } req_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_mode;
  logic signed [15:0]      in_linear_speed;
  logic signed [15:0]      in_turn_rate;
  logic                    in_armed_in;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_kind;
  logic signed [CMD_W-1:0] out_steering;
  logic signed [CMD_W-1:0] out_throttle;
  logic                    out_armed_flag;
  logic                    out_override_flag;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  vehicle_command_mixer_top #(.TIMEOUT_TICKS(TIMEOUT_TICKS)) u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_linear_speed, .in_turn_rate, .in_armed_in,
    .out_valid, .out_stall, .out_kind, .out_steering, .out_throttle,
    .out_armed_flag, .out_override_flag,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register file copy plus arm / override / tick tracking.
  // Starts at the reset values of the block.
  // ---------------------------------------------------------------------------
  cfg_t        mix_cfg = '{16'd1908, -11'sd90, 11'sd75, 12'd143, 11'sd27,
                           12'd143, -11'sd27, 2'd2};
  logic        armed_q = 1'b0;
  logic        ovr_q   = 1'b0;
  logic [7:0]  ticks_q = 8'hFF;

  cmd_t        cmd_pending[$];   // expected results, oldest first
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;   // requests left in the current sender burst
  bit          hold_req = 1'b0;  // main asks the receiver for a long hold-off

  // Directed part, run under the reset register values.
  req_row_t dir_rows [18] = '{
    // tick straight out of reset: disarmed, no override
    '{MODE_TICK,   16'sd0,      16'sd0,      1'b0, 1,  1'b1,
      '{KIND_STATUS, 11'sd0, 11'sd0, 1'b0, 1'b0}},
    // drive requests while disarmed: nothing out, manual still engages override
    '{MODE_AUTO,   16'sd512,    16'sd256,    1'b0, 1,  1'b0, '0},
    '{MODE_MANUAL, 16'sd256,    -16'sd256,   1'b1, 1,  1'b0, '0},
    '{MODE_TICK,   16'sd0,      16'sd0,      1'b0, 1,  1'b1,
      '{KIND_STATUS, 11'sd0, 11'sd0, 1'b0, 1'b1}},
    '{MODE_ARM,    16'sd0,      16'sd0,      1'b1, 1,  1'b0, '0},
    // autonomous request blocked by the override
    '{MODE_AUTO,   16'sd300,    16'sd100,    1'b0, 1,  1'b0, '0},
    // zero speed: no trim, zero throttle
    '{MODE_MANUAL, 16'sd0,      16'sd0,      1'b0, 1,  1'b1,
      '{KIND_DRIVE, 11'sd0, 11'sd0, 1'b1, 1'b1}},
    // field extremes, both outputs saturate (steering inverted by default)
    '{MODE_MANUAL, 16'sd32767,  16'sd32767,  1'b1, 1,  1'b1,
      '{KIND_DRIVE, -11'sd1000, 11'sd1000, 1'b1, 1'b1}},
    '{MODE_MANUAL, -16'sd32768, -16'sd32768, 1'b0, 1,  1'b1,
      '{KIND_DRIVE, 11'sd1000, -11'sd1000, 1'b1, 1'b1}},
    // smallest speeds, floor rounding of negative products
    '{MODE_MANUAL, 16'sd1,      16'sd0,      1'b1, 1,  1'b0, '0},
    '{MODE_MANUAL, -16'sd1,     -16'sd1,     1'b0, 1,  1'b0, '0},
    '{MODE_MANUAL, 16'sd0,      16'sd200,    1'b1, 1,  1'b0, '0},
    // override holds through TIMEOUT_TICKS ticks, clears on the next one
    '{MODE_TICK,   16'sd0,      16'sd0,      1'b0, 20, 1'b0, '0},
    '{MODE_TICK,   16'sd0,      16'sd0,      1'b0, 1,  1'b1,
      '{KIND_STATUS, 11'sd0, 11'sd0, 1'b1, 1'b0}},
    '{MODE_AUTO,   16'sd384,    -16'sd64,    1'b0, 1,  1'b0, '0},
    // disarm: drive dropped, status shows disarmed
    '{MODE_ARM,    16'sd0,      16'sd0,      1'b0, 1,  1'b0, '0},
    '{MODE_AUTO,   16'sd384,    -16'sd64,    1'b1, 1,  1'b0, '0},
    '{MODE_TICK,   16'sd0,      16'sd0,      1'b0, 1,  1'b1,
      '{KIND_STATUS, 11'sd0, 11'sd0, 1'b0, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic signed [CMD_W-1:0] clamp_cmd(input longint v);
    if (v > 1000) return 11'sd1000;
    if (v < -1000) return -11'sd1000;
    return v[CMD_W-1:0];
  endfunction

  // steering / throttle mix for one drive request; no output while disarmed
  function automatic bit mix_drive(input logic signed [15:0] spd, input logic signed [15:0] turn,
                                   output cmd_t r);
    longint steer;
    longint thr;
    bit     fwd;
    r = '0;
    if (!armed_q) return 1'b0;
    fwd   = spd > 0;
    thr   = 0;
    steer = (longint'(turn) * longint'(mix_cfg.steer_gain)) >>> 8;
    if (spd > 0) begin
      steer += $signed(mix_cfg.forward_trim);
      thr = ((longint'(spd) * longint'(mix_cfg.forward_scale)) >>> 8)
            + $signed(mix_cfg.forward_offset);
    end else if (spd < 0) begin
      steer += $signed(mix_cfg.reverse_trim);
      thr = ((longint'(spd) * longint'(mix_cfg.reverse_scale)) >>> 8)
            + $signed(mix_cfg.reverse_offset);
    end
    if (mix_cfg.invert_mask[0]) begin
      thr = -thr;
      fwd = !fwd;
    end
    // throttle against the commanded direction is dropped, not clamped
    if ((fwd && thr < 0) || (!fwd && thr > 0)) thr = 0;
    if (mix_cfg.invert_mask[1]) steer = -steer;
    r.kind  = KIND_DRIVE;
    r.steer = clamp_cmd(steer);
    r.thr   = clamp_cmd(thr);
    r.armed = 1'b1;
    r.ovr   = ovr_q;
    return 1'b1;
  endfunction

  // state update and expected result for one accepted request
  function automatic bit predict_command(input mode_t m, input logic signed [15:0] spd,
                                         input logic signed [15:0] turn, input logic arm,
                                         output cmd_t r);
    bit emit = 1'b0;
    r = '0;
    case (m)
      MODE_AUTO: begin
        if (!ovr_q) emit = mix_drive(spd, turn, r);
      end
      MODE_MANUAL: begin
        ticks_q = 8'd0;
        ovr_q   = 1'b1;
        emit    = mix_drive(spd, turn, r);
      end
      MODE_ARM: armed_q = arm;
      default: begin
        if (ticks_q != 8'hFF) ticks_q++;
        if (ticks_q > TIMEOUT_TICKS) ovr_q = 1'b0;
        r    = '{KIND_STATUS, 11'sd0, 11'sd0, armed_q, ovr_q};
        emit = 1'b1;
      end
    endcase
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers (all called at a rising edge)
  // ---------------------------------------------------------------------------
  // Q7.8 value: zero, extremes, small and moderate ranges, or full 16 bits
  function automatic logic signed [15:0] pick_q78();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = 1;
          default: v = -1;
        endcase
      end
      2, 3: v = int'($urandom_range(0, 512)) - 256;
      4, 5: v = int'($urandom_range(0, 4096)) - 2048;
      default: v = int'($urandom());
    endcase
    return v[15:0];
  endfunction

  // offer one request, wait for it to be taken, record what it should produce,
  // then apply sender pacing (bursts separated by random gaps)
  task automatic issue(input mode_t m, input logic signed [15:0] spd,
                       input logic signed [15:0] turn, input logic arm,
                       input bit typed, input cmd_t want, output bit emit);
    cmd_t        r;
    int unsigned gap;
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_linear_speed <= spd;
    in_turn_rate    <= turn;
    in_armed_in     <= arm;
    do @(posedge clk); while (in_stall);
    emit = predict_command(m, spd, turn, arm, r);
    if (typed) cmd_pending.push_back(want);
    else if (emit) cmd_pending.push_back(r);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // let every in-flight request finish; requests with no result still need the
  // pipeline latency before a register may be touched
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cmd_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEER_GAIN:     mix_cfg.steer_gain     = val[15:0];
      REG_FORWARD_TRIM:   mix_cfg.forward_trim   = val[CMD_W-1:0];
      REG_REVERSE_TRIM:   mix_cfg.reverse_trim   = val[CMD_W-1:0];
      REG_FORWARD_SCALE:  mix_cfg.forward_scale  = val[11:0];
      REG_FORWARD_OFFSET: mix_cfg.forward_offset = val[CMD_W-1:0];
      REG_REVERSE_SCALE:  mix_cfg.reverse_scale  = val[11:0];
      REG_REVERSE_OFFSET: mix_cfg.reverse_offset = val[CMD_W-1:0];
      default:            mix_cfg.invert_mask    = val[1:0];
    endcase
  endtask

  task automatic program_mixer(input int gain, input int f_trim, input int r_trim,
                               input int f_scale, input int f_off, input int r_scale,
                               input int r_off, input int inv);
    write_reg(REG_STEER_GAIN, gain);
    write_reg(REG_FORWARD_TRIM, f_trim);
    write_reg(REG_REVERSE_TRIM, r_trim);
    write_reg(REG_FORWARD_SCALE, f_scale);
    write_reg(REG_FORWARD_OFFSET, f_off);
    write_reg(REG_REVERSE_SCALE, r_scale);
    write_reg(REG_REVERSE_OFFSET, r_off);
    write_reg(REG_INVERT_MASK, inv);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern (none, light, heavy, toggling) is redrawn at random
  // intervals. On request from main it runs the LONG_HOLD hold-off once, so
  // the block fills and pushes back on its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pattern;
    int unsigned pattern_left;
    int unsigned hold_left;
    bit          hold_done;
    pattern      = 0;
    pattern_left = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern      = $urandom_range(0, 3);
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        case (pattern)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation.
  // Values are sampled at the edge, before any update scheduled by it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_pending.size() == 0) begin
        report_mismatch("unexpected result, kind", out_kind, -1);
      end else begin
        w = cmd_pending.pop_front();
        if (out_kind !== w.kind) report_mismatch("kind", out_kind, w.kind);
        if (out_steering !== w.steer) report_mismatch("steering", out_steering, w.steer);
        if (out_throttle !== w.thr) report_mismatch("throttle", out_throttle, w.thr);
        if (out_armed_flag !== w.armed) report_mismatch("armed_flag", out_armed_flag, w.armed);
        if (out_override_flag !== w.ovr)
          report_mismatch("override_flag", out_override_flag, w.ovr);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when no handshake of any kind happens for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned idle_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases each under its own
  // register setting (extremes first), draining the block before every write.
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int unsigned counted;
    int unsigned pick;
    int unsigned manual_pct;
    bit          emit;
    bit          held;
    mode_t       m;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_AUTO;
    in_linear_speed <= '0;
    in_turn_rate    <= '0;
    in_armed_in     <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_STEER_GAIN;
    cfg_data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps)
        issue(dir_rows[i].mode, dir_rows[i].speed, dir_rows[i].turn, dir_rows[i].arm,
              dir_rows[i].typed, dir_rows[i].want, emit);
    end

    // random phases
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: program_mixer(65535, 1000, -1000, 4095, -1000, 4095, 1000, 3);
        1: program_mixer(0, -1000, 1000, 0, 1000, 0, -1000, 0);
        2: program_mixer(1908, -90, 75, 143, 27, 143, -27, 1);
        default:
          program_mixer(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 3000),
                        int'($urandom_range(0, 2000)) - 1000,
                        int'($urandom_range(0, 2000)) - 1000,
                        $urandom_range(0, 4095),
                        int'($urandom_range(0, 2000)) - 1000,
                        $urandom_range(0, 4095),
                        int'($urandom_range(0, 2000)) - 1000,
                        $urandom_range(0, 3));
      endcase

      // manual share decides how often the override is engaged vs timed out
      case (ph % 3)
        0: manual_pct = 1;
        1: manual_pct = 4;
        default: manual_pct = 12;
      endcase

      counted = 0;
      held    = 1'b0;
      issue(MODE_ARM, pick_q78(), pick_q78(), 1'b1, 1'b0, '0, emit);
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < manual_pct) m = MODE_MANUAL;
        else if (pick < manual_pct + 4) m = MODE_ARM;
        else if (pick < manual_pct + 34) m = MODE_TICK;
        else m = MODE_AUTO;
        issue(m, pick_q78(), pick_q78(), ($urandom_range(0, 6) != 0), 1'b0, '0, emit);
        counted++;
        // back-pressure test: receiver stops while we keep offering
        if (ph == 3 && counted >= 40 && !held) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
